>>> rtl/hsvbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsvbr_pkg;

    // One input transfer: a hue and the two ends of the ramp.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation_floor;
        logic [7:0] brightness_max;
    } hsv_in_t;

    // One result transfer: a single ramp entry.
    typedef struct packed {
        logic [3:0] level_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } rgb_out_t;

    // Per-entry tag that rides along the pipeline next to the valid bits.
    typedef struct packed {
        logic [3:0] level_index;
        logic       last;
    } lvl_tag_t;

    // Six hue sectors, named by the colors at their two ends.
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } sector_t;

    localparam int CHAN_W     = 8;
    localparam int CHAN_MAX   = 255;
    localparam int QUOT_W     = 16;
    localparam int DIV_STAGES = 4;

endpackage

`default_nettype wire

>>> rtl/hsvbr_chan_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Rounds one channel: out = min(255, floor(floor(y / DIVISOR) / 255)).
// Four register stages, all advancing together on en.
module hsvbr_chan_div #(
    parameter int DIVISOR = 256,
    parameter int Y_WIDTH = 24
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [Y_WIDTH-1:0]             y,
    output logic      [hsvbr_pkg::CHAN_W-1:0]   chan
);

    localparam logic [Y_WIDTH-1:0] RECIP =
        Y_WIDTH'((64'd1 << Y_WIDTH) / 64'(DIVISOR));
    localparam logic [Y_WIDTH-1:0] DIV_W = Y_WIDTH'(DIVISOR);
    localparam int QW = hsvbr_pkg::QUOT_W;

    logic [Y_WIDTH-1:0]   y_a_reg;
    logic [QW-1:0]        q0_reg;
    logic [QW-1:0]        z_reg;
    logic [QW-1:0]        zc_reg;
    logic [7:0]           w0_reg;
    logic [7:0]           chan_reg;

    logic [2*Y_WIDTH-1:0] prod;
    logic [QW-1:0]        q0_next;
    logic [Y_WIDTH-1:0]   qd;
    logic [Y_WIDTH-1:0]   rem_a;
    logic [QW-1:0]        z_next;
    logic [QW+7:0]        zm;
    logic [7:0]           w0_next;
    logic [QW-1:0]        w255;
    logic [QW-1:0]        rem_b;
    logic [8:0]           w;
    logic [7:0]           chan_next;

    always_comb
    begin
        // Reciprocal estimate is exact or one low.
        prod    = (2*Y_WIDTH)'(y) * (2*Y_WIDTH)'(RECIP);
        q0_next = QW'(prod >> Y_WIDTH);

        qd     = Y_WIDTH'(q0_reg) * DIV_W;
        rem_a  = y_a_reg - qd;
        z_next = q0_reg + QW'(rem_a >= DIV_W);

        // Multiply by 257/65536 approximates division by 255, again at most one low.
        zm      = {z_reg, 8'd0} + (QW+8)'(z_reg);
        w0_next = zm[QW+7:QW];

        w255  = {w0_reg, 8'd0} - QW'(w0_reg);
        rem_b = zc_reg - w255;
        w     = {1'b0, w0_reg} + 9'(rem_b >= QW'(hsvbr_pkg::CHAN_MAX));
        chan_next = (w > 9'(hsvbr_pkg::CHAN_MAX)) ? 8'(hsvbr_pkg::CHAN_MAX) : w[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_a_reg  <= y;
            q0_reg   <= q0_next;
            z_reg    <= z_next;
            zc_reg   <= z_reg;
            w0_reg   <= w0_next;
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

>>> rtl/hsv_brightness_ramp_to_rgb.sv
// Brightness ramp generator: each accepted input transfer (hue, saturation
// floor, peak brightness) yields LEVELS result transfers, darkest level first,
// the last one marked by the last bit. Level i has brightness
// brightness_max*(i+1)/LEVELS and a saturation that climbs from the floor
// toward 255 as brightness drops; each entry is a six-sector HSV-to-RGB
// conversion carried out in exact fixed point, each channel rounded half up.
// The sequencer issues one level per cycle while the result side does not
// stall, feeding a seven-stage pipeline, and the next input is taken on the
// same cycle the previous one issues its last level. Backpressure on the
// result side freezes the whole pipeline; nothing is lost or repeated. There
// is no configuration and no stored state between inputs.
`timescale 1ns / 1ps
`default_nettype none

module hsv_brightness_ramp_to_rgb #(
    parameter int LEVELS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire hsvbr_pkg::hsv_in_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output hsvbr_pkg::rgb_out_t      result
);

    // Widths of the fixed-point terms. Every channel is P*A over the common
    // denominator LEVELS^2*255*256, with P = brightness_max*n.
    localparam int IW       = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int NW       = $clog2(LEVELS + 1);
    localparam int PW       = 8 + NW;
    localparam int SW       = $clog2(255 * LEVELS + 1);
    localparam int AV       = LEVELS * 65280;
    localparam int AW       = $clog2(AV + 1);
    localparam int DEN_SQ   = LEVELS * LEVELS;
    localparam int YW       = $clog2(DEN_SQ * 65280);
    localparam int EW       = YW + 8;
    localparam int HALF_DEN = DEN_SQ * 255 * 128;
    localparam int STAGES   = 3 + hsvbr_pkg::DIV_STAGES;

    // Whole pipeline moves when the output register is free or being taken.
    logic adv;
    assign adv = !result_valid || result_ready;

    // Sequencer: holds the current input and walks the level counter.
    logic                     busy_reg;
    logic [IW-1:0]            lvl_reg;
    hsvbr_pkg::sector_t       sector_reg;
    logic [8:0]               ff_reg;
    logic [7:0]               sat_reg;
    logic [7:0]               val_reg;
    logic                     lvl_last;
    logic                     issue;
    logic                     take;
    logic [10:0]              h6;
    logic [7:0]               frac;

    assign lvl_last   = (lvl_reg == IW'(LEVELS - 1));
    assign issue      = busy_reg && adv;
    assign item_ready = !busy_reg || (adv && lvl_last);
    assign take       = item_valid && item_ready;

    always_comb
    begin
        h6   = 11'(item.hue) * 11'd6;
        frac = h6[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            lvl_reg  <= '0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                lvl_reg  <= '0;
            end
            else if (issue)
            begin
                busy_reg <= !lvl_last;
                lvl_reg  <= lvl_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sector_reg <= hsvbr_pkg::sector_t'(h6[10:8]);
            // Odd sectors run the secondary component downward.
            ff_reg     <= h6[8] ? (9'd256 - 9'(frac)) : 9'(frac);
            sat_reg    <= item.saturation_floor;
            val_reg    <= item.brightness_max;
        end
    end

    // Valid bits and tags travel beside the data through all stages.
    logic [STAGES-1:0]        vld_reg;
    hsvbr_pkg::lvl_tag_t      tag_reg [STAGES];
    hsvbr_pkg::lvl_tag_t      tag_in;

    assign tag_in.level_index = 4'(lvl_reg);
    assign tag_in.last        = lvl_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], busy_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= tag_in;
            for (int k = 1; k < STAGES; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // Stage 1: P = brightness*n and t = (255 - floor)*n.
    // The saturation numerator over LEVELS is then 255*LEVELS - t.
    logic [NW-1:0]            n_cur;
    logic [PW-1:0]            p1_reg;
    logic [PW-1:0]            t1_reg;
    hsvbr_pkg::sector_t       sec1_reg;
    logic [8:0]               ff1_reg;

    assign n_cur = NW'(lvl_reg) + NW'(1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg   <= PW'(val_reg) * PW'(n_cur);
            t1_reg   <= PW'(8'(hsvbr_pkg::CHAN_MAX) - sat_reg) * PW'(n_cur);
            sec1_reg <= sector_reg;
            ff1_reg  <= ff_reg;
        end
    end

    // Stage 2: per-entry weights. m weight is t*256, x weight adds chroma*ff.
    logic [SW-1:0]            s_num;
    logic [AW-1:0]            ax_next;
    logic [AW-1:0]            ax2_reg;
    logic [AW-1:0]            am2_reg;
    logic [PW-1:0]            p2_reg;
    hsvbr_pkg::sector_t       sec2_reg;

    always_comb
    begin
        s_num   = SW'(255 * LEVELS) - SW'(t1_reg);
        ax_next = AW'(s_num) * AW'(ff1_reg) + (AW'(t1_reg) << 8);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg  <= ax_next;
            am2_reg  <= AW'(t1_reg) << 8;
            p2_reg   <= p1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    // Stage 3: route weights to channels by sector, scale by P, add half the
    // denominator and drop the factor 256.
    logic [AW-1:0]            a_r;
    logic [AW-1:0]            a_g;
    logic [AW-1:0]            a_b;
    logic [PW+AW-1:0]         prod_r;
    logic [PW+AW-1:0]         prod_g;
    logic [PW+AW-1:0]         prod_b;
    logic [EW-1:0]            sum_r;
    logic [EW-1:0]            sum_g;
    logic [EW-1:0]            sum_b;
    logic [YW-1:0]            y_r_reg;
    logic [YW-1:0]            y_g_reg;
    logic [YW-1:0]            y_b_reg;

    always_comb
    begin
        unique case (sec2_reg)
            hsvbr_pkg::SECTOR_RED_YELLOW:
            begin
                a_r = AW'(AV); a_g = ax2_reg; a_b = am2_reg;
            end
            hsvbr_pkg::SECTOR_YELLOW_GREEN:
            begin
                a_r = ax2_reg; a_g = AW'(AV); a_b = am2_reg;
            end
            hsvbr_pkg::SECTOR_GREEN_CYAN:
            begin
                a_r = am2_reg; a_g = AW'(AV); a_b = ax2_reg;
            end
            hsvbr_pkg::SECTOR_CYAN_BLUE:
            begin
                a_r = am2_reg; a_g = ax2_reg; a_b = AW'(AV);
            end
            hsvbr_pkg::SECTOR_BLUE_MAGENTA:
            begin
                a_r = ax2_reg; a_g = am2_reg; a_b = AW'(AV);
            end
            default:
            begin
                a_r = AW'(AV); a_g = am2_reg; a_b = ax2_reg;
            end
        endcase

        prod_r = (PW+AW)'(p2_reg) * (PW+AW)'(a_r);
        prod_g = (PW+AW)'(p2_reg) * (PW+AW)'(a_g);
        prod_b = (PW+AW)'(p2_reg) * (PW+AW)'(a_b);
        sum_r  = EW'(prod_r) + EW'(HALF_DEN);
        sum_g  = EW'(prod_g) + EW'(HALF_DEN);
        sum_b  = EW'(prod_b) + EW'(HALF_DEN);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_r_reg <= YW'(sum_r >> 8);
            y_g_reg <= YW'(sum_g >> 8);
            y_b_reg <= YW'(sum_b >> 8);
        end
    end

    // Stages 4 to 7: divide by LEVELS^2, then by 255, one lane per channel.
    logic [7:0] red_q;
    logic [7:0] green_q;
    logic [7:0] blue_q;

    hsvbr_chan_div #(.DIVISOR(DEN_SQ), .Y_WIDTH(YW)) u_div_r (
        .clk  (clk),
        .en   (adv),
        .y    (y_r_reg),
        .chan (red_q)
    );

    hsvbr_chan_div #(.DIVISOR(DEN_SQ), .Y_WIDTH(YW)) u_div_g (
        .clk  (clk),
        .en   (adv),
        .y    (y_g_reg),
        .chan (green_q)
    );

    hsvbr_chan_div #(.DIVISOR(DEN_SQ), .Y_WIDTH(YW)) u_div_b (
        .clk  (clk),
        .en   (adv),
        .y    (y_b_reg),
        .chan (blue_q)
    );

    assign result_valid       = vld_reg[STAGES-1];
    assign result.level_index = tag_reg[STAGES-1].level_index;
    assign result.last        = tag_reg[STAGES-1].last;
    assign result.red         = red_q;
    assign result.green       = green_q;
    assign result.blue        = blue_q;

endmodule

`default_nettype wire

>>> dv/hsv_brightness_ramp_to_rgb_test.sv
`timescale 1ns / 1ps

// Testbench for the HSV brightness ramp generator.
// An initial block loads input transfers into a queue. A clocked driver
// presents them, and a clocked monitor checks every result transfer against
// a ramp predicted from the accepted input. The run has three handshake
// phases. In the first, the sender idles often and the receiver idles more.
// In the second, the two are swapped. In the third, neither side idles.
// Between phases the sender holds off until every predicted entry has come.
module hsv_brightness_ramp_to_rgb_test;

    localparam int LEVELS        = 16;
    localparam int ITEMS_PER_RUN = 83;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 32;
    // Common denominator of every channel numerator in the ramp.
    localparam longint unsigned RAMP_DEN = longint'(LEVELS) * LEVELS * 255 * 256;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    hsvbr_pkg::hsv_in_t   item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    hsvbr_pkg::rgb_out_t  result;

    // Inputs that are waiting to be sent, and ramp entries that have not
    // arrived yet, oldest first.
    hsvbr_pkg::hsv_in_t   color_q[$];
    hsvbr_pkg::rgb_out_t  ramp_q[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    logic        color_taken   = 1'b0;

    hsv_brightness_ramp_to_rgb #(
        .LEVELS(LEVELS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Rounds a channel numerator to nearest, with halves going up, and then
    // clamps the result to the 8-bit range.
    function automatic logic [7:0] round_channel(input longint unsigned num);
        longint unsigned q;
        q = (num + RAMP_DEN / 2) / RAMP_DEN;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Predicts the LEVELS ramp entries of one input and queues them. The
    // arithmetic is exact: every quantity is a numerator over RAMP_DEN.
    task automatic predict_ramp(input hsvbr_pkg::hsv_in_t x);
        longint unsigned hue, sat, val, h6, frac, ff, n, s_num;
        longint unsigned v_d, c_d, x_d, m_d, r, g, b;
        hsvbr_pkg::sector_t sec;
        hsvbr_pkg::rgb_out_t e;
        hue = x.hue;
        sat = x.saturation_floor;
        val = x.brightness_max;
        h6 = hue * 6;
        sec = hsvbr_pkg::sector_t'(h6[10:8]);
        frac = h6[7:0];
        // The secondary component falls across odd sectors and rises across
        // even sectors.
        ff = h6[8] ? (256 - frac) : frac;
        for (int i = 0; i < LEVELS; i++)
        begin
            n = i + 1;
            // Saturation climbs toward full as the level gets darker.
            s_num = sat * LEVELS + (255 - sat) * (LEVELS - n);
            v_d = val * n * LEVELS * 255 * 256;
            c_d = val * n * s_num * 256;
            x_d = val * n * s_num * ff;
            m_d = v_d - c_d;
            r = 0;
            g = 0;
            b = 0;
            case (sec)
                hsvbr_pkg::SECTOR_RED_YELLOW:
                begin
                    r = c_d;
                    g = x_d;
                end
                hsvbr_pkg::SECTOR_YELLOW_GREEN:
                begin
                    r = x_d;
                    g = c_d;
                end
                hsvbr_pkg::SECTOR_GREEN_CYAN:
                begin
                    g = c_d;
                    b = x_d;
                end
                hsvbr_pkg::SECTOR_CYAN_BLUE:
                begin
                    g = x_d;
                    b = c_d;
                end
                hsvbr_pkg::SECTOR_BLUE_MAGENTA:
                begin
                    r = x_d;
                    b = c_d;
                end
                default:
                begin
                    r = c_d;
                    b = x_d;
                end
            endcase
            e.level_index = i[3:0];
            e.red         = round_channel(r + m_d);
            e.green       = round_channel(g + m_d);
            e.blue        = round_channel(b + m_d);
            e.last        = (i == LEVELS - 1);
            ramp_q = {ramp_q, e};
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor. Every result transfer is checked against the oldest predicted
    // entry, and every input transfer adds the ramp of that input. Results
    // are compared before the new ramp is added, so a result that shows up
    // too early cannot match an entry from the same clock edge.
    always @(posedge clk)
    begin
        hsvbr_pkg::rgb_out_t want;
        if (result_valid && result_ready)
        begin
            if (ramp_q.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = ramp_q.pop_front();
                check_field("level_index", want.level_index, result.level_index);
                check_field("red", want.red, result.red);
                check_field("green", want.green, result.green);
                check_field("blue", want.blue, result.blue);
                check_field("last", want.last, result.last);
            end
        end
        if (item_valid && item_ready)
            predict_ramp(item);
        color_taken <= item_valid && item_ready;
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Driver. It changes the inputs on the falling edge. A presented input is
    // held until its transfer, and only then is the next one presented, or
    // valid is dropped for an idle cycle.
    always @(negedge clk)
    begin
        if (!item_valid || color_taken)
        begin
            if (color_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item       <= color_q.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic add_color(input logic [7:0] hue, input logic [7:0] sat, input logic [7:0] val);
        hsvbr_pkg::hsv_in_t x;
        x.hue              = hue;
        x.saturation_floor = sat;
        x.brightness_max   = val;
        color_q = {color_q, x};
    endtask

    // Picks a byte value. The two extremes come up more often than a
    // uniform pick would give them.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_random_colors(input int count);
        for (int k = 0; k < count; k++)
            add_color(pick_byte(), pick_byte(), pick_byte());
    endtask

    // Waits until every queued input has been transferred and every
    // predicted entry has arrived. The short delay after the edge lets the
    // clocked blocks settle before the queues are read.
    task automatic wait_ramps_done();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (color_q.size() != 0 || item_valid || ramp_q.size() != 0);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 55;

        // Directed inputs. These cover black, white, full and zero
        // saturation floors, and the darkest nonzero peak.
        add_color(8'd0, 8'd0, 8'd0);
        add_color(8'd255, 8'd255, 8'd255);
        add_color(8'd0, 8'd0, 8'd255);
        add_color(8'd0, 8'd255, 8'd255);
        add_color(8'd255, 8'd0, 8'd255);
        add_color(8'd100, 8'd255, 8'd1);
        // One hue from the middle of each of the six sectors.
        add_color(8'd21, 8'd128, 8'd200);
        add_color(8'd64, 8'd128, 8'd200);
        add_color(8'd106, 8'd128, 8'd200);
        add_color(8'd149, 8'd128, 8'd200);
        add_color(8'd192, 8'd128, 8'd200);
        add_color(8'd234, 8'd128, 8'd200);
        // Hues on either side of the sector boundaries, including one with
        // a zero fraction.
        add_color(8'd42, 8'd0, 8'd255);
        add_color(8'd43, 8'd0, 8'd255);
        add_color(8'd85, 8'd0, 8'd255);
        add_color(8'd86, 8'd0, 8'd255);
        add_color(8'd128, 8'd0, 8'd255);
        add_color(8'd171, 8'd0, 8'd255);
        add_color(8'd213, 8'd0, 8'd255);
        add_color(8'd214, 8'd0, 8'd255);
        add_random_colors(ITEMS_PER_RUN);
        wait_ramps_done();

        // The receiver is now the side that mostly keeps up, and the sender
        // is the one that idles.
        send_idle_pct = 55;
        recv_idle_pct = 21;
        add_random_colors(ITEMS_PER_RUN);
        wait_ramps_done();

        // Neither side idles, so inputs arrive back to back.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_colors(ITEMS_PER_RUN);
        wait_ramps_done();

        // Give any extra result time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog. It ends the run if no transfer happens on either side for
    // too long.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t ns: timeout, no transfer in %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
